### rtl/linear_probe_hash_map_assert.svh
// ---------------------------------------------------------------------------
// linear_probe_hash_map assertion macros
// concurrent assertion shorthands, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LPHM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lphm assertion failed");
// next-cycle implication
`define LPHM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lphm assertion failed");
`else
`define LPHM_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define LPHM_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### rtl/lphm_pkg.sv
// ---------------------------------------------------------------------------
// lphm_pkg
// shared types and constants of the linear probing hash map
// ---------------------------------------------------------------------------
`default_nettype none

package lphm_pkg;

  localparam int unsigned KEY_W            = 64;
  localparam int unsigned ID_W             = 32;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned KEY_BIT_W        = $clog2(KEY_W);
  localparam int unsigned CAPACITY_DEFAULT = 1024;

  // home slot reduction folds the key in 16-bit chunks
  localparam int unsigned HASH_CHUNK_W     = 16;
  localparam int unsigned HASH_CHUNKS      = KEY_W / HASH_CHUNK_W;

  localparam logic [ID_W-1:0] NO_ID = '1;

  // response status codes
  localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  // request action codes
  localparam logic ACTION_FIND = 1'b0;
  localparam logic ACTION_PUT  = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [KEY_W-1:0] key;
  } lphm_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_MUL,
    S_HASH_SUB,
    S_HASH_FIX,
    S_PROBE,
    S_RESP
  } lphm_state_e;

endpackage

`default_nettype wire

### rtl/lphm_if.sv
// ---------------------------------------------------------------------------
// lphm channel interfaces
// request and response valid/ready channels of the hash map
// ---------------------------------------------------------------------------
`default_nettype none

interface lphm_req_if;
  import lphm_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key;
  logic [ID_W-1:0]  new_id;

  modport source (output valid, output action, output key, output new_id, input ready);
  modport sink   (input valid, input action, input key, input new_id, output ready);
endinterface

interface lphm_rsp_if;
  import lphm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     found_id;

  modport source (output valid, output status, output found_id, input ready);
  modport sink   (input valid, input status, input found_id, output ready);
endinterface

`default_nettype wire

### rtl/lphm_slot_ram.sv
// ---------------------------------------------------------------------------
// lphm_slot_ram
// slot memory, one write port and one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module lphm_slot_ram #(
  parameter int unsigned Depth = lphm_pkg::CAPACITY_DEFAULT,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire lphm_pkg::lphm_entry_t wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output      lphm_pkg::lphm_entry_t rdata_o
);
  import lphm_pkg::*;

  lphm_entry_t mem [Depth];
  lphm_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/linear_probe_hash_map.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_map
// open-addressing hash map from 64-bit keys to 32-bit ids, linear probing
// ---------------------------------------------------------------------------
// Each request transaction is a find or a put; each gives exactly one response
// transaction. The home slot is key modulo CAPACITY (the key's low bits when
// CAPACITY is a power of two); probing walks one slot up at a time through a
// single-port-read slot memory and wraps to slot 0. A find ends on an empty
// slot (miss), the first equal key (hit) or a full lap (miss); a put stores
// into the first empty slot, or is refused with the full status when it would
// leave more than half the slots occupied. One request is worked at a time.
// An item goes through accept, slot read, compare and response, with one slot
// read issued per cycle from the memory's read port while probing; a refused
// put goes from accept straight to the response. When CAPACITY is not a power
// of two the home slot is reduced by one shared 32-bit multiplier, folding the
// key in 16-bit chunks, each by a multiply, a subtract and a fix step. After
// reset a clearing pass marks every slot empty, and no request is accepted
// until it ends.
`default_nettype none

`include "linear_probe_hash_map_assert.svh"

module linear_probe_hash_map #(
  parameter int unsigned CAPACITY = lphm_pkg::CAPACITY_DEFAULT
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lphm_req_if.sink    req_i,
  lphm_rsp_if.source  rsp_o
);
  import lphm_pkg::*;

  localparam int unsigned SW          = $clog2(CAPACITY);
  localparam int unsigned HALF        = CAPACITY / 2;
  localparam bit          IS_POW2     = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int unsigned CHUNK_IDX_W = $clog2(HASH_CHUNKS);

  localparam logic [SW-1:0]          LAST_SLOT = SW'(CAPACITY - 1);
  localparam logic [SW-1:0]          HALF_CNT  = SW'(HALF);
  localparam logic [SW:0]            CAP_EXT   = (SW + 1)'(CAPACITY);
  localparam logic [CHUNK_IDX_W-1:0] TOP_CHUNK = CHUNK_IDX_W'(HASH_CHUNKS - 1);
  // floor(2^32 / CAPACITY): times a 32-bit value it undershoots the quotient by at most one
  localparam logic [63:0]            RECIP_W   = (64'd1 << 32) / 64'(CAPACITY);
  localparam logic [31:0]            RECIP     = RECIP_W[31:0];
  localparam logic [31:0]            CAP_W32   = 32'(CAPACITY);

  // control state
  lphm_state_e         state_q, state_d;
  logic [SW-1:0]       addr_q, addr_d;         // clear pointer, then probe read pointer
  logic [SW-1:0]       chk_addr_q, chk_addr_d; // slot whose data is on the read port
  logic                chk_vld_q, chk_vld_d;   // read data belongs to this probe
  logic [SW-1:0]       n_q, n_d;               // slots checked so far
  logic [SW-1:0]       count_q, count_d;       // occupied slots
  logic [SW-1:0]       rem_q, rem_d;           // running home slot remainder
  logic [CHUNK_IDX_W-1:0] chunk_q, chunk_d;    // key chunk being folded in, top first
  logic [31:0]         quo_q, quo_d;           // quotient estimate of this chunk
  logic [SW:0]         rest_q, rest_d;         // remainder estimate, below twice CAPACITY
  logic                rsp_valid_q, rsp_valid_d;

  // payload
  logic                action_q;
  logic [KEY_W-1:0]    key_q;
  logic [ID_W-1:0]     new_id_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [ID_W-1:0]     res_id_q, res_id_d;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [ID_W-1:0]     rsp_id_q;

  // slot memory ports
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  lphm_entry_t   ram_wdata;
  logic          ram_re;
  lphm_entry_t   rd_entry;

  // control strobes
  logic accept;
  logic table_full;
  logic slot_empty;
  logic key_hit;
  logic resolve;
  logic ins_en;
  logic res_load;
  logic rsp_load;

  // shared unit: one multiplier for the modulo, slot increment with wrap
  logic [SW-1:0]           next_addr;
  logic [KEY_BIT_W-1:0]    chunk_base;
  logic [HASH_CHUNK_W-1:0] key_chunk;
  logic [31:0]             fold_val;   // remainder so far with the next chunk appended
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [63:0]             mul_p;
  logic [SW:0]             rem_fix;

  assign next_addr  = (addr_q == LAST_SLOT) ? '0 : addr_q + 1'b1;
  assign chunk_base = KEY_BIT_W'(chunk_q * HASH_CHUNK_W);
  assign key_chunk  = key_q[chunk_base +: HASH_CHUNK_W];
  assign fold_val   = {HASH_CHUNK_W'(rem_q), key_chunk};

  // quotient estimate first, then the product that comes off the folded value
  always_comb begin
    if (state_q == S_HASH_SUB) begin
      mul_a = quo_q;
      mul_b = CAP_W32;
    end else begin
      mul_a = fold_val;
      mul_b = RECIP;
    end
  end

  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign rem_fix = (rest_q >= CAP_EXT) ? rest_q - CAP_EXT : rest_q;

  assign accept     = req_i.valid && req_i.ready;
  assign table_full = count_q >= HALF_CNT;
  assign slot_empty = chk_vld_q && !rd_entry.valid;
  assign key_hit    = chk_vld_q && rd_entry.valid && (rd_entry.key == key_q);

  // a put stops on the first empty slot; a find also on a hit or a full lap
  always_comb begin
    if (action_q == ACTION_PUT) begin
      resolve = slot_empty;
    end else begin
      resolve = slot_empty || key_hit || (chk_vld_q && (n_q == LAST_SLOT));
    end
  end

  lphm_slot_ram #(
    .Depth (CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (rd_entry)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (addr_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_i.action == ACTION_PUT && table_full) begin
            state_d = S_RESP;
          end else if (IS_POW2) begin
            state_d = S_PROBE;
          end else begin
            state_d = S_HASH_MUL;
          end
        end
      end
      S_HASH_MUL: begin
        state_d = S_HASH_SUB;
      end
      S_HASH_SUB: begin
        state_d = S_HASH_FIX;
      end
      S_HASH_FIX: begin
        if (chunk_q == '0) begin
          state_d = S_PROBE;
        end else begin
          state_d = S_HASH_MUL;
        end
      end
      S_PROBE: begin
        if (resolve) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '{valid: 1'b0, id: NO_ID, key: '0};
    ram_re      = 1'b0;
    ins_en      = 1'b0;
    res_load    = 1'b0;
    rsp_load    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        res_load    = accept && (req_i.action == ACTION_PUT) && table_full;
      end
      S_PROBE: begin
        ram_re   = 1'b1;
        res_load = resolve;
        if (action_q == ACTION_PUT && resolve) begin
          ram_we    = 1'b1;
          ram_waddr = chk_addr_q;
          ram_wdata = '{valid: 1'b1, id: new_id_q, key: key_q};
          ins_en    = 1'b1;
        end
      end
      S_RESP: begin
        rsp_load = !rsp_valid_q || rsp_o.ready;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    addr_d     = addr_q;
    chk_addr_d = chk_addr_q;
    chk_vld_d  = 1'b0;
    n_d        = n_q;
    rem_d      = rem_q;
    chunk_d    = chunk_q;
    quo_d      = quo_q;
    rest_d     = rest_q;
    count_d    = ins_en ? count_q + 1'b1 : count_q;

    case (state_q)
      S_CLEAR: begin
        addr_d = next_addr;
      end
      S_IDLE: begin
        n_d     = '0;
        rem_d   = '0;
        chunk_d = TOP_CHUNK;
        if (accept && IS_POW2) begin
          addr_d = req_i.key[SW-1:0];
        end
      end
      S_HASH_MUL: begin
        quo_d = mul_p[63:32];
      end
      S_HASH_SUB: begin
        rest_d = (SW + 1)'(fold_val - mul_p[31:0]);
      end
      S_HASH_FIX: begin
        // one compare-subtract settles the estimate
        rem_d   = rem_fix[SW-1:0];
        chunk_d = chunk_q - 1'b1;
        if (chunk_q == '0) begin
          addr_d = rem_fix[SW-1:0];
        end
      end
      S_PROBE: begin
        // one slot read issues per cycle; the previous one is checked now
        addr_d     = next_addr;
        chk_addr_d = addr_q;
        chk_vld_d  = !resolve;
        if (chk_vld_q) begin
          n_d = n_q + 1'b1;
        end
      end
      default: begin
        addr_d = addr_q;
      end
    endcase

    // result of the item, parked until the output register frees up
    if (state_q == S_PROBE && action_q == ACTION_PUT) begin
      res_status_d = STATUS_INSERTED;
      res_id_d     = NO_ID;
    end else if (state_q == S_PROBE && key_hit) begin
      res_status_d = STATUS_HIT;
      res_id_d     = rd_entry.id;
    end else if (state_q == S_PROBE) begin
      res_status_d = STATUS_MISS;
      res_id_d     = NO_ID;
    end else begin
      res_status_d = STATUS_FULL;
      res_id_d     = NO_ID;
    end

    // output register: a fresh load wins over a completed transaction
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      chk_addr_q  <= '0;
      chk_vld_q   <= 1'b0;
      n_q         <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      chunk_q     <= '0;
      quo_q       <= '0;
      rest_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      chk_addr_q  <= chk_addr_d;
      chk_vld_q   <= chk_vld_d;
      n_q         <= n_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      chunk_q     <= chunk_d;
      quo_q       <= quo_d;
      rest_q      <= rest_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= req_i.action;
      key_q    <= req_i.key;
      new_id_q <= req_i.new_id;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
    end
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_id_q     <= res_id_q;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.found_id = rsp_id_q;

  // occupancy never passes half the table
  `LPHM_ASSERT_NOW(count_limit_a, clk_i, rst_ni, 1'b1, count_q <= HALF_CNT)
  // every insertion bumps the entry count by exactly one
  `LPHM_ASSERT_NEXT(insert_count_a, clk_i, rst_ni, ins_en, count_q == $past(count_q) + 1'b1)
  // only a hit carries a real id
  `LPHM_ASSERT_NOW(miss_id_a, clk_i, rst_ni, rsp_o.valid && rsp_o.status != STATUS_HIT, rsp_o.found_id == NO_ID)
  // one request at a time
  `LPHM_ASSERT_NEXT(busy_after_accept_a, clk_i, rst_ni, accept, !req_i.ready)

endmodule

`default_nettype wire

### dv/linear_probe_hash_map_test.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_map_test
// self-checking bench: a short list of directed finds and puts, then random
// traffic under four idling patterns. Every request transaction is mirrored
// in a local copy of the slot table, and every response transaction is
// compared field by field with the oldest reply still owed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_hash_map_test;
  import lphm_pkg::*;

  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned SLOT_BITS   = $clog2(CAPACITY);
  localparam int unsigned PHASE_OPS   = 358;    // random requests per idling phase
  localparam int unsigned STALL_LIMIT = 20000;  // cycles with no transaction at all
  localparam int unsigned DRAIN_WAIT  = 64;
  localparam int unsigned NUM_ROWS    = 20;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
  } reply_t;

  // one directed request; the reply is typed in only when pinned is set
  typedef struct packed {
    logic                pinned;
    logic                action;
    logic [KEY_W-1:0]    key;
    logic [ID_W-1:0]     new_id;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
  } op_row_t;

  // home slots used above: 0x0 -> 0, all ones -> 1023, 0x400 -> 0, 0x7ff -> 1023
  localparam op_row_t DIRECTED_OPS [NUM_ROWS] = '{
    // empty table after the clearing pass: both finds miss
    '{1'b1, ACTION_FIND, 64'h0,                 32'h0,         STATUS_MISS,     NO_ID},
    '{1'b1, ACTION_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,       STATUS_MISS,     NO_ID},
    // first puts land on their home slots, 0x400 collides with key 0
    '{1'b1, ACTION_PUT,  64'h0,                 32'h0,         STATUS_INSERTED, NO_ID},
    '{1'b1, ACTION_PUT,  64'hFFFF_FFFF_FFFF_FFFF, NO_ID,       STATUS_INSERTED, NO_ID},
    '{1'b1, ACTION_PUT,  64'h400,               32'h5,         STATUS_INSERTED, NO_ID},
    '{1'b0, ACTION_FIND, 64'h0,                 32'hFFFF_0000, STATUS_MISS,     NO_ID},
    // an id of all ones is an ordinary entry and must come back as a hit
    '{1'b0, ACTION_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,       STATUS_MISS,     NO_ID},
    '{1'b0, ACTION_FIND, 64'h400,               32'h0,         STATUS_MISS,     NO_ID},
    // home slot is the last one: the walk wraps through slot 0
    '{1'b0, ACTION_PUT,  64'h7FF,               32'h1234_5678, STATUS_MISS,     NO_ID},
    '{1'b0, ACTION_FIND, 64'h7FF,               32'h0,         STATUS_MISS,     NO_ID},
    // duplicate key goes further along, the find still returns the first one
    '{1'b0, ACTION_PUT,  64'h0,                 32'hAAAA_5555, STATUS_MISS,     NO_ID},
    '{1'b0, ACTION_FIND, 64'h0,                 32'h0,         STATUS_MISS,     NO_ID},
    // same home slot, absent key: walk to the end of the cluster
    '{1'b0, ACTION_FIND, 64'hC00,               32'h0,         STATUS_MISS,     NO_ID},
    '{1'b0, ACTION_FIND, 64'h8000_0000_0000_0000, 32'h0,       STATUS_MISS,     NO_ID},
    '{1'b0, ACTION_PUT,  64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, STATUS_MISS,   NO_ID},
    '{1'b0, ACTION_PUT,  64'h5555_5555_5555_5555, 32'hAAAA_AAAA, STATUS_MISS,   NO_ID},
    '{1'b0, ACTION_FIND, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0,       STATUS_MISS,     NO_ID},
    '{1'b0, ACTION_FIND, 64'h5555_5555_5555_5555, 32'h0,       STATUS_MISS,     NO_ID},
    '{1'b0, ACTION_FIND, 64'h7FE,               32'h0,         STATUS_MISS,     NO_ID},
    '{1'b0, ACTION_FIND, 64'h3FF,               32'h0,         STATUS_MISS,     NO_ID}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lphm_req_if req_ch ();
  lphm_rsp_if rsp_ch ();

  linear_probe_hash_map #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // local copy of the slot table; occupancy is its own flag, not an id value
  logic [KEY_W-1:0] slot_key  [CAPACITY];
  logic [ID_W-1:0]  slot_id   [CAPACITY];
  bit               slot_used [CAPACITY];
  int unsigned      used_slots;

  reply_t           replies_due [$];   // replies owed by the block, oldest first
  logic [KEY_W-1:0] stored_keys [$];   // keys sent in puts, reused for hits
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  // apply one request to the local table and return the reply it earns
  function automatic reply_t hash_map_op(input logic act, input logic [KEY_W-1:0] k,
                                         input logic [ID_W-1:0] id);
    reply_t      r;
    int unsigned s;
    r.status   = STATUS_MISS;
    r.found_id = NO_ID;
    s = 32'(k % 64'(CAPACITY));
    if (act == ACTION_FIND) begin
      // walk until an empty slot, the first equal key or a full lap
      for (int unsigned n = 0; n < CAPACITY; n++) begin
        if (!slot_used[s]) break;
        if (slot_key[s] == k) begin
          r.status   = STATUS_HIT;
          r.found_id = slot_id[s];
          break;
        end
        s = (s + 1 == CAPACITY) ? 0 : s + 1;
      end
    end else if (2 * (used_slots + 1) > CAPACITY) begin
      // would leave more than half the slots occupied: table untouched
      r.status = STATUS_FULL;
    end else begin
      while (slot_used[s]) s = (s + 1 == CAPACITY) ? 0 : s + 1;
      slot_key[s]  = k;
      slot_id[s]   = id;
      slot_used[s] = 1'b1;
      used_slots++;
      r.status = STATUS_INSERTED;
    end
    return r;
  endfunction

  // random request: keys cluster around a few home slots so that probe
  // chains grow and wrap, finds mostly reuse stored keys or near misses
  task automatic pick_random_op(output logic act, output logic [KEY_W-1:0] k,
                                output logic [ID_W-1:0] id);
    int unsigned roll;
    int unsigned hot;
    act  = ($urandom_range(99) < 50) ? ACTION_PUT : ACTION_FIND;
    k    = {$urandom, $urandom};
    roll = $urandom_range(99);
    if ($urandom_range(99) < 15) begin
      hot = $urandom_range(3);
      case (hot)
        0:       k[SLOT_BITS-1:0] = SLOT_BITS'(CAPACITY - 1);
        1:       k[SLOT_BITS-1:0] = SLOT_BITS'(CAPACITY - 2);
        2:       k[SLOT_BITS-1:0] = '0;
        default: k[SLOT_BITS-1:0] = SLOT_BITS'(CAPACITY / 2);
      endcase
    end
    if (stored_keys.size() != 0) begin
      if (act == ACTION_FIND && roll < 55) begin
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else if (act == ACTION_FIND && roll < 70) begin
        // same home slot, one upper bit off: must not match
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
        k[$urandom_range(KEY_W - 1, SLOT_BITS)] ^= 1'b1;
      end else if (act == ACTION_PUT && roll < 10) begin
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end
    end
    roll = $urandom_range(99);
    if (roll < 5) id = NO_ID;
    else if (roll < 8) id = '0;
    else id = $urandom;
    if (act == ACTION_PUT) stored_keys.push_back(k);
  endtask

  // present one request from a falling edge until it is taken
  task automatic issue(input logic act, input logic [KEY_W-1:0] k,
                       input logic [ID_W-1:0] id, input bit pinned, input reply_t pinned_reply);
    reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid  = 1'b1;
    req_ch.action = act;
    req_ch.key    = k;
    req_ch.new_id = id;
    do @(posedge clk_i); while (!req_ch.ready);
    // the table copy is always updated, even when the reply is typed in
    predicted = hash_map_op(act, k, id);
    replies_due.push_back(pinned ? pinned_reply : predicted);
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
  endtask

  // response side: random back-pressure, changed at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // response checking and the no-progress watchdog, both at the rising edge
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unrequested response", 64'h0, {30'h0, rsp_ch.status, rsp_ch.found_id});
        end else begin
          want = replies_due.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(rsp_ch.status));
          if (rsp_ch.found_id !== want.found_id)
            report_mismatch("found_id", 64'(want.found_id), 64'(rsp_ch.found_id));
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("linear_probe_hash_map test failed");
        $finish;
      end
    end
  end

  initial begin
    logic             act;
    logic [KEY_W-1:0] k;
    logic [ID_W-1:0]  id;
    reply_t           pinned_reply;

    // every input known from time zero, with reset asserted
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACTION_FIND;
    req_ch.key     = '0;
    req_ch.new_id  = '0;
    rsp_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    used_slots     = 0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      slot_key[i]  = '0;
      slot_id[i]   = NO_ID;
      slot_used[i] = 1'b0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows, back to back; the clearing pass just delays the first accept
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      pinned_reply.status   = DIRECTED_OPS[r].status;
      pinned_reply.found_id = DIRECTED_OPS[r].found_id;
      issue(DIRECTED_OPS[r].action, DIRECTED_OPS[r].key, DIRECTED_OPS[r].new_id,
            DIRECTED_OPS[r].pinned, pinned_reply);
    end

    // random traffic: no idling, sender gaps, receiver stalls, then both;
    // puts are half the mix, so the half-full limit is hit in the later phases
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int unsigned n = 0; n < PHASE_OPS; n++) begin
        pick_random_op(act, k, id);
        issue(act, k, id, 1'b0, '0);
      end
    end
    req_ch.valid = 1'b0;

    // let every owed reply arrive, then watch for stray responses
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("linear_probe_hash_map test passed");
    end else begin
      $display("linear_probe_hash_map test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/lphm_pkg.sv
rtl/lphm_if.sv
rtl/lphm_slot_ram.sv
rtl/linear_probe_hash_map.sv
dv/linear_probe_hash_map_test.sv
